FILE: sv/cpu_6502_instruction_execute_macros.svh
// Assertion macros shared by the 6502 execute block.
`ifndef CPU_6502_INSTRUCTION_EXECUTE_MACROS_SVH
`define CPU_6502_INSTRUCTION_EXECUTE_MACROS_SVH

// Checked only outside reset.
`define CPU6502_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPU6502_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/cpu6502_pkg.sv
// Shared types, constants and opcode length table for the 6502 execute block.
`timescale 1ns / 1ps

package cpu6502_pkg;

   localparam logic [7:0] FLAG_C   = 8'h01;
   localparam logic [7:0] FLAG_Z   = 8'h02;
   localparam logic [7:0] FLAG_I   = 8'h04;
   localparam logic [7:0] FLAG_D   = 8'h08;
   localparam logic [7:0] FLAG_B   = 8'h10;
   localparam logic [7:0] FLAG_ONE = 8'h20;
   localparam logic [7:0] FLAG_V   = 8'h40;
   localparam logic [7:0] FLAG_N   = 8'h80;

   localparam logic [7:0]  STATUS_RESET     = 8'h24;
   localparam logic [7:0]  SP_RESET         = 8'hFF;
   localparam logic [15:0] STACK_BASE_RESET = 16'h0100;
   localparam logic [15:0] RESET_PC_RESET   = 16'h0000;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STACK_BASE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_PC   = 1'b1;

   // Instruction length, two bits per opcode, one word per high nibble.
   // Zero marks an undocumented opcode.
   localparam logic [31:0] OPLEN_ROWS [16] = '{
      32'h3C19_2809, 32'h3C0D_280A, 32'h3F19_2A0B, 32'h3C0D_280A,
      32'h3F19_2809, 32'h3C0D_280A, 32'h3F19_2809, 32'h3C0D_280A,
      32'h3F11_2A08, 32'h0C1D_2A0A, 32'h3F19_2A2A, 32'h3F1D_2A0A,
      32'h3F19_2A0A, 32'h3C0D_280A, 32'h3F19_2A0A, 32'h3C0D_280A
   };

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  p;
      logic [15:0] pc;
   } arch_state_type;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  operand;
      logic [15:0] ea;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [7:0]  p3;
      logic [15:0] bv;
   } exec_item_type;

   typedef struct packed {
      arch_state_type   state;
      logic             illegal;
      logic [1:0]       wr_count;
      logic [2:0][15:0] wr_addr;
      logic [2:0][7:0]  wr_data;
   } exec_result_type;

   function automatic logic [1:0] op_length(input logic [7:0] op);
      logic [31:0] row;
      row = OPLEN_ROWS[op[7:4]];
      return row[{op[3:0], 1'b0} +: 2];
   endfunction

endpackage

FILE: sv/cpu6502_exec.sv
// Single-pass instruction execute logic: next architectural state and write list.
`timescale 1ns / 1ps

module cpu6502_exec (
   input  cpu6502_pkg::arch_state_type  state_i,
   input  cpu6502_pkg::exec_item_type   item_i,
   input  logic [15:0]                  stack_base_i,
   output cpu6502_pkg::exec_result_type result_o
);
   import cpu6502_pkg::*;

   arch_state_type   st;
   logic [1:0]       len;
   logic [1:0]       cnt;
   logic [2:0][15:0] wa;
   logic [2:0][7:0]  wd;
   logic [7:0]       op, v, r, src, addm, flag_sel;
   logic [8:0]       sum;
   logic [15:0]      ret;
   logic [2:0]       aaa;

   always_comb begin
      st   = state_i;
      op   = item_i.opcode;
      v    = item_i.operand;
      aaa  = op[7:5];
      len  = op_length(op);
      cnt  = 2'd0;
      wa   = '0;
      wd   = '0;
      r    = 8'h00;
      ret  = 16'h0000;
      src  = (op[3:0] == 4'hA) ? state_i.a : v;
      addm = (aaa == 3'd7) ? ~v : v;
      sum  = {1'b0, state_i.a} + {1'b0, addm} + {8'h00, state_i.p[0]};
      unique case (aaa[2:1])
         2'd0:    flag_sel = state_i.p & FLAG_N;
         2'd1:    flag_sel = state_i.p & FLAG_V;
         2'd2:    flag_sel = state_i.p & FLAG_C;
         default: flag_sel = state_i.p & FLAG_Z;
      endcase

      if (len == 2'd0) begin
         st.pc = state_i.pc + 16'd1;
      end else begin
         st.pc = state_i.pc + {14'd0, len};
         if (op[1:0] == 2'b01) begin
            unique case (aaa)
               3'd0: begin st.a = state_i.a | v; r = st.a; end
               3'd1: begin st.a = state_i.a & v; r = st.a; end
               3'd2: begin st.a = state_i.a ^ v; r = st.a; end
               3'd4: begin
                  wa[0] = item_i.ea; wd[0] = state_i.a; cnt = 2'd1;
               end
               3'd5: begin st.a = v; r = v; end
               3'd6: begin
                  st.p[0] = state_i.a >= v;
                  r = state_i.a - v;
               end
               default: begin
                  st.a    = sum[7:0];
                  st.p[0] = sum[8];
                  st.p[6] = ((state_i.a ^ sum[7:0]) & (addm ^ sum[7:0]) & 8'h80) != 8'h00;
                  r       = sum[7:0];
               end
            endcase
            if (aaa != 3'd4) begin
               st.p[7] = r[7];
               st.p[1] = r == 8'h00;
            end
         end else if (op[1:0] == 2'b10) begin
            if (op[7] && op[3:0] == 4'hA) begin
               unique case (op)
                  8'h8A: begin st.a = state_i.x; r = st.a; end
                  8'h9A: begin st.sp = state_i.x; r = st.sp; end
                  8'hAA: begin st.x = state_i.a; r = st.x; end
                  8'hBA: begin st.x = state_i.sp; r = st.x; end
                  8'hCA: begin st.x = state_i.x - 8'd1; r = st.x; end
                  default: r = 8'h00;
               endcase
               // TXS and NOP leave the flags alone
               if (op != 8'h9A && op != 8'hEA) begin
                  st.p[7] = r[7];
                  st.p[1] = r == 8'h00;
               end
            end else if (!aaa[2]) begin
               unique case (aaa[1:0])
                  2'd0: begin r = {src[6:0], 1'b0};          st.p[0] = src[7]; end
                  2'd1: begin r = {src[6:0], state_i.p[0]};  st.p[0] = src[7]; end
                  2'd2: begin r = {1'b0, src[7:1]};          st.p[0] = src[0]; end
                  default: begin r = {state_i.p[0], src[7:1]}; st.p[0] = src[0]; end
               endcase
               st.p[7] = r[7];
               st.p[1] = r == 8'h00;
               if (op[3:0] == 4'hA) begin
                  st.a = r;
               end else begin
                  wa[0] = item_i.ea; wd[0] = r; cnt = 2'd1;
               end
            end else begin
               unique case (aaa[1:0])
                  2'd0: begin wa[0] = item_i.ea; wd[0] = state_i.x; cnt = 2'd1; end
                  2'd1: begin st.x = v; st.p[7] = v[7]; st.p[1] = v == 8'h00; end
                  2'd2: begin
                     r = v - 8'd1; st.p[7] = r[7]; st.p[1] = r == 8'h00;
                     wa[0] = item_i.ea; wd[0] = r; cnt = 2'd1;
                  end
                  default: begin
                     r = v + 8'd1; st.p[7] = r[7]; st.p[1] = r == 8'h00;
                     wa[0] = item_i.ea; wd[0] = r; cnt = 2'd1;
                  end
               endcase
            end
         end else if (op[4:0] == 5'h10) begin
            if ((flag_sel != 8'h00) == aaa[0]) begin
               st.pc = st.pc + {{8{v[7]}}, v};
            end
         end else begin
            unique case (op)
               8'h00: begin
                  // return address skips the padding byte after BRK
                  ret   = st.pc + 16'd1;
                  wa[0] = stack_base_i + {8'h00, state_i.sp};
                  wd[0] = ret[15:8];
                  wa[1] = stack_base_i + {8'h00, state_i.sp - 8'd1};
                  wd[1] = ret[7:0];
                  wa[2] = stack_base_i + {8'h00, state_i.sp - 8'd2};
                  wd[2] = state_i.p | FLAG_B | FLAG_ONE;
                  cnt   = 2'd3;
                  st.sp = state_i.sp - 8'd3;
                  st.p  = state_i.p | FLAG_I;
                  st.pc = item_i.bv;
               end
               8'h20: begin
                  ret   = st.pc - 16'd1;
                  wa[0] = stack_base_i + {8'h00, state_i.sp};
                  wd[0] = ret[15:8];
                  wa[1] = stack_base_i + {8'h00, state_i.sp - 8'd1};
                  wd[1] = ret[7:0];
                  cnt   = 2'd2;
                  st.sp = state_i.sp - 8'd2;
                  st.pc = item_i.ea;
               end
               8'h40: begin
                  st.p  = (item_i.p1 & ~FLAG_B) | FLAG_ONE;
                  st.pc = {item_i.p3, item_i.p2};
                  st.sp = state_i.sp + 8'd3;
               end
               8'h60: begin
                  st.pc = {item_i.p2, item_i.p1} + 16'd1;
                  st.sp = state_i.sp + 8'd2;
               end
               8'h4C, 8'h6C: st.pc = item_i.ea;
               8'h08: begin
                  wa[0] = stack_base_i + {8'h00, state_i.sp};
                  wd[0] = state_i.p | FLAG_B | FLAG_ONE;
                  cnt   = 2'd1;
                  st.sp = state_i.sp - 8'd1;
               end
               8'h18: st.p = state_i.p & ~FLAG_C;
               8'h28: begin
                  st.p  = (item_i.p1 & ~FLAG_B) | FLAG_ONE;
                  st.sp = state_i.sp + 8'd1;
               end
               8'h38: st.p = state_i.p | FLAG_C;
               8'h48: begin
                  wa[0] = stack_base_i + {8'h00, state_i.sp};
                  wd[0] = state_i.a;
                  cnt   = 2'd1;
                  st.sp = state_i.sp - 8'd1;
               end
               8'h58: st.p = state_i.p & ~FLAG_I;
               8'h68: begin
                  st.a = item_i.p1; st.p[7] = item_i.p1[7]; st.p[1] = item_i.p1 == 8'h00;
                  st.sp = state_i.sp + 8'd1;
               end
               8'h78: st.p = state_i.p | FLAG_I;
               8'h88: begin
                  st.y = state_i.y - 8'd1; st.p[7] = st.y[7]; st.p[1] = st.y == 8'h00;
               end
               8'h98: begin
                  st.a = state_i.y; st.p[7] = st.a[7]; st.p[1] = st.a == 8'h00;
               end
               8'hA8: begin
                  st.y = state_i.a; st.p[7] = st.y[7]; st.p[1] = st.y == 8'h00;
               end
               8'hB8: st.p = state_i.p & ~FLAG_V;
               8'hC8: begin
                  st.y = state_i.y + 8'd1; st.p[7] = st.y[7]; st.p[1] = st.y == 8'h00;
               end
               8'hD8: st.p = state_i.p & ~FLAG_D;
               8'hE8: begin
                  st.x = state_i.x + 8'd1; st.p[7] = st.x[7]; st.p[1] = st.x == 8'h00;
               end
               8'hF8: st.p = state_i.p | FLAG_D;
               default: begin
                  unique case (aaa)
                     3'd1: begin
                        st.p[1] = (state_i.a & v) == 8'h00;
                        st.p[7] = v[7];
                        st.p[6] = v[6];
                     end
                     3'd4: begin wa[0] = item_i.ea; wd[0] = state_i.y; cnt = 2'd1; end
                     3'd5: begin st.y = v; st.p[7] = v[7]; st.p[1] = v == 8'h00; end
                     3'd6: begin
                        r = state_i.y - v; st.p[0] = state_i.y >= v;
                        st.p[7] = r[7]; st.p[1] = r == 8'h00;
                     end
                     3'd7: begin
                        r = state_i.x - v; st.p[0] = state_i.x >= v;
                        st.p[7] = r[7]; st.p[1] = r == 8'h00;
                     end
                     default: r = 8'h00;
                  endcase
               end
            endcase
         end
      end

      result_o.state    = st;
      result_o.illegal  = len == 2'd0;
      result_o.wr_count = cnt;
      result_o.wr_addr  = wa;
      result_o.wr_data  = wd;
   end

endmodule

FILE: sv/cpu_6502_instruction_execute.sv
// 6502 instruction execute block: one documented instruction per input item.
// Results are registered: they appear in the cycle after the item is accepted.
// Throughput: an item yields one to three results, one per cycle while rsp_stall is low; a
// new item is taken in the cycle its last result leaves, so one item per cycle without writes.
// The rate is set by the single result register draining the write list.
// Reset (synchronous): A/X/Y 0, SP FF, P 24, PC 0000, stack base 0100.
`timescale 1ns / 1ps

module cpu_6502_instruction_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [cpu6502_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_operand,
   input  logic [15:0] req_effective_address,
   input  logic [7:0]  req_pulled_first,
   input  logic [7:0]  req_pulled_second,
   input  logic [7:0]  req_pulled_third,
   input  logic [15:0] req_break_vector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_last_of_run,
   output logic        rsp_illegal_opcode,
   output logic [7:0]  rsp_reg_a,
   output logic [7:0]  rsp_reg_x,
   output logic [7:0]  rsp_reg_y,
   output logic [7:0]  rsp_stack_ptr,
   output logic [7:0]  rsp_flags,
   output logic [15:0] rsp_program_counter
);
   import cpu6502_pkg::*;

   `include "cpu_6502_instruction_execute_macros.svh"

   // architectural state, updated when an item is accepted
   arch_state_type  state_ff;
   logic [15:0]     stack_base_ff;
   logic            error_seen_ff;

   // result buffer: holds the write list of the item in flight
   logic             busy_ff;
   logic [1:0]       idx_ff, idx_in;
   logic             illegal_ff;
   logic [1:0]       count_ff;
   logic [2:0][15:0] wr_addr_ff;
   logic [2:0][7:0]  wr_data_ff;

   exec_item_type   item;
   exec_result_type result;

   logic accept, take, last, wr_here;

   assign item.opcode  = req_opcode;
   assign item.operand = req_operand;
   assign item.ea      = req_effective_address;
   assign item.p1      = req_pulled_first;
   assign item.p2      = req_pulled_second;
   assign item.p3      = req_pulled_third;
   assign item.bv      = req_break_vector;

   cpu6502_exec u_exec (
      .state_i      (state_ff),
      .item_i       (item),
      .stack_base_i (stack_base_ff),
      .result_o     (result)
   );

   // a write-free item still gives one result
   assign wr_here = idx_ff < count_ff;
   assign last    = (count_ff == 2'd0) || (idx_ff == count_ff - 2'd1);
   assign take    = busy_ff && !rsp_stall;
   // next item enters as the last result of the current one leaves
   assign req_stall = busy_ff && !(take && last);
   assign accept    = req_valid && !req_stall;
   assign idx_in    = idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.a    <= 8'h00;
         state_ff.x    <= 8'h00;
         state_ff.y    <= 8'h00;
         state_ff.sp   <= SP_RESET;
         state_ff.p    <= STATUS_RESET;
         state_ff.pc   <= RESET_PC_RESET;
         stack_base_ff <= STACK_BASE_RESET;
         error_seen_ff <= 1'b0;
         busy_ff       <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         if (accept) begin
            state_ff      <= result.state;
            error_seen_ff <= error_seen_ff | result.illegal;
            busy_ff       <= 1'b1;
            idx_ff        <= 2'd0;
         end else if (take) begin
            if (last) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_in;
            end
         end
         // csr writes must arrive only while idle; the block itself does not enforce this
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_STACK_BASE: stack_base_ff <= csr_write_data;
               CSR_RESET_PC:   state_ff.pc   <= csr_write_data;
               default:        stack_base_ff <= stack_base_ff;
            endcase
         end
      end
   end

   // payload side of the buffer, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         illegal_ff <= result.illegal;
         count_ff   <= result.wr_count;
         wr_addr_ff <= result.wr_addr;
         wr_data_ff <= result.wr_data;
      end
   end

   assign rsp_valid           = busy_ff;
   assign rsp_write_valid     = wr_here;
   assign rsp_write_address   = wr_here ? wr_addr_ff[idx_ff] : 16'h0000;
   assign rsp_write_data      = wr_here ? wr_data_ff[idx_ff] : 8'h00;
   assign rsp_last_of_run     = last;
   assign rsp_illegal_opcode  = illegal_ff;
   assign rsp_reg_a           = state_ff.a;
   assign rsp_reg_x           = state_ff.x;
   assign rsp_reg_y           = state_ff.y;
   assign rsp_stack_ptr       = state_ff.sp;
   assign rsp_flags           = state_ff.p;
   assign rsp_program_counter = state_ff.pc;

   `CPU6502_ASSERT_ALL(a_idle_after_reset, reset |=> !rsp_valid, "result valid after reset")
   `CPU6502_ASSERT_RUN(a_illegal_sticky, rsp_valid && rsp_illegal_opcode |-> error_seen_ff,
      "illegal result without sticky error")
   `CPU6502_ASSERT_RUN(a_status_fixed_bits, state_ff.p[5] && !state_ff.p[4],
      "status bit 5 clear or B set")
   `CPU6502_ASSERT_RUN(a_nowrite_last, rsp_valid && !rsp_write_valid |-> rsp_last_of_run,
      "write-free result not last")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the 6502 instruction execute block.
`timescale 1ns / 1ps

module tb_top;
   import cpu6502_pkg::*;

   // Opcodes with their own behavior, and a few used by the directed items.
   localparam logic [7:0] OP_BRK = 8'h00, OP_PHP = 8'h08, OP_ASL_A = 8'h0A, OP_CLC = 8'h18;
   localparam logic [7:0] OP_JSR = 8'h20, OP_BIT_ZP = 8'h24, OP_PLP = 8'h28, OP_ROL_A = 8'h2A;
   localparam logic [7:0] OP_BMI = 8'h30, OP_SEC = 8'h38, OP_RTI = 8'h40, OP_EOR_IMM = 8'h49;
   localparam logic [7:0] OP_PHA = 8'h48, OP_LSR_A = 8'h4A, OP_JMP = 8'h4C, OP_CLI = 8'h58;
   localparam logic [7:0] OP_RTS = 8'h60, OP_PLA = 8'h68, OP_ADC_IMM = 8'h69, OP_JMP_IND = 8'h6C;
   localparam logic [7:0] OP_ROR_ABS = 8'h6E, OP_SEI = 8'h78, OP_STY_ZP = 8'h84;
   localparam logic [7:0] OP_STX_ZP = 8'h86, OP_DEY = 8'h88, OP_TXA = 8'h8A, OP_STA_ABS = 8'h8D;
   localparam logic [7:0] OP_TYA = 8'h98, OP_STA_ABSY = 8'h99, OP_TXS = 8'h9A;
   localparam logic [7:0] OP_LDY_IMM = 8'hA0, OP_LDX_IMM = 8'hA2, OP_TAY = 8'hA8;
   localparam logic [7:0] OP_LDA_IMM = 8'hA9, OP_TAX = 8'hAA, OP_CLV = 8'hB8, OP_TSX = 8'hBA;
   localparam logic [7:0] OP_CPY_IMM = 8'hC0, OP_DEC_ZP = 8'hC6, OP_INY = 8'hC8;
   localparam logic [7:0] OP_DEX = 8'hCA, OP_BNE = 8'hD0, OP_CLD = 8'hD8, OP_CPX_IMM = 8'hE0;
   localparam logic [7:0] OP_INX = 8'hE8, OP_SBC_IMM = 8'hE9, OP_INC_ABS = 8'hEE;
   localparam logic [7:0] OP_BEQ = 8'hF0, OP_SED = 8'hF8, OP_BAD_LOW = 8'h02, OP_BAD_HIGH = 8'hFF;

   // Column groups (low two opcode bits) and row selects (top three bits).
   localparam logic [1:0] GRP_ALU = 2'd1, GRP_RMW = 2'd2;
   localparam logic [2:0] ROW_ORA = 3'd0, ROW_AND = 3'd1, ROW_EOR = 3'd2, ROW_ADC = 3'd3;
   localparam logic [2:0] ROW_STORE = 3'd4, ROW_LOAD = 3'd5, ROW_CMP = 3'd6;
   localparam logic [2:0] ROW_ASL = 3'd0, ROW_ROL = 3'd1, ROW_LSR = 3'd2;
   localparam logic [2:0] ROW_DEC = 3'd6, ROW_BIT = 3'd1, ROW_CPY = 3'd6;

   // Instruction length per opcode; zero marks an undocumented code.
   localparam bit [1:0] INSN_LEN [256] = '{
      1,2,0,0,0,2,2,0,1,2,1,0,0,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
      3,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
      1,2,0,0,0,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
      1,2,0,0,0,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
      0,2,0,0,2,2,2,0,1,0,1,0,3,3,3,0, 2,2,0,0,2,2,2,0,1,3,1,0,0,3,0,0,
      2,2,2,0,2,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,2,2,2,0,1,3,1,0,3,3,3,0,
      2,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
      2,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0, 2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0
   };

   typedef struct packed {
      logic        wr_valid;
      logic [15:0] wr_addr;
      logic [7:0]  wr_data;
      logic        last;
      logic        illegal;
      logic [7:0]  a, x, y, sp, p;
      logic [15:0] pc;
   } bus_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_STACK_BASE;
   logic [15:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_opcode = '0, req_operand = '0;
   logic [15:0] req_effective_address = '0, req_break_vector = '0;
   logic [7:0] req_pulled_first = '0, req_pulled_second = '0, req_pulled_third = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_write_valid, rsp_last_of_run, rsp_illegal_opcode;
   logic [15:0] rsp_write_address, rsp_program_counter;
   logic [7:0] rsp_write_data, rsp_reg_a, rsp_reg_x, rsp_reg_y, rsp_stack_ptr, rsp_flags;

   cpu_6502_instruction_execute DUT (.*);

   always #10 clock = ~clock;

   // Predicted machine state, mirrors the block.
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
   logic [15:0] cpu_pc, cfg_stack_base, cfg_reset_pc;
   logic [15:0] bus_addr [3];
   logic [7:0]  bus_data [3];
   int          bus_count;

   exec_item_type  instr_queue [$];    // items waiting to be driven
   bus_result_type bus_expected [$];   // results the block still owes
   int  send_idle_pct = 0, recv_idle_pct = 0;
   int  mismatches = 0;
   logic took_item = 1'b0;

   function automatic void set_flag(logic [7:0] m, logic on);
      cpu_p = on ? (cpu_p | m) : (cpu_p & ~m);
   endfunction

   function automatic void set_nz(logic [7:0] r);
      set_flag(FLAG_Z, r == 8'h00);
      set_flag(FLAG_N, r[7]);
   endfunction

   function automatic void bus_write(logic [15:0] addr, logic [7:0] data);
      bus_addr[bus_count] = addr;
      bus_data[bus_count] = data;
      bus_count++;
   endfunction

   function automatic void stack_push(logic [7:0] b);
      bus_write(cfg_stack_base + {8'h00, cpu_sp}, b);
      cpu_sp = cpu_sp - 8'd1;
   endfunction

   function automatic void add_binary(logic [7:0] m);
      logic [8:0] s;
      s = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[0]};
      set_flag(FLAG_C, s[8]);
      set_flag(FLAG_V, ((cpu_a ^ s[7:0]) & (m ^ s[7:0]) & 8'h80) != 8'h00);
      cpu_a = s[7:0];
      set_nz(cpu_a);
   endfunction

   function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
      set_flag(FLAG_C, r >= m);
      set_nz(r - m);
   endfunction

   function automatic void pull_status(logic [7:0] b);
      cpu_p = (b & ~FLAG_B) | FLAG_ONE;
   endfunction

   // Executes one instruction on the predicted state.
   function automatic void execute_instr(exec_item_type it);
      logic [2:0] row;
      logic [7:0] op, v, src, r;
      logic [7:0] bmask;
      logic [15:0] ret;
      op = it.opcode;
      v = it.operand;
      row = op[7:5];
      if (op[1:0] == GRP_ALU) begin
         case (row)
            ROW_ORA: begin cpu_a = cpu_a | v; set_nz(cpu_a); end
            ROW_AND: begin cpu_a = cpu_a & v; set_nz(cpu_a); end
            ROW_EOR: begin cpu_a = cpu_a ^ v; set_nz(cpu_a); end
            ROW_ADC: add_binary(v);
            ROW_STORE: bus_write(it.ea, cpu_a);
            ROW_LOAD: begin cpu_a = v; set_nz(v); end
            ROW_CMP: compare_reg(cpu_a, v);
            default: add_binary(~v);
         endcase
         return;
      end
      if (op[1:0] == GRP_RMW) begin
         if (op[7] && op[3:0] == 4'hA) begin
            case (op)
               OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
               OP_TXS: cpu_sp = cpu_x;
               OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
               OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
               OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
               default: ;
            endcase
            return;
         end
         if (!row[2]) begin
            src = (op[3:0] == 4'hA) ? cpu_a : v;
            case (row)
               ROW_ASL: r = {src[6:0], 1'b0};
               ROW_ROL: r = {src[6:0], cpu_p[0]};
               ROW_LSR: r = {1'b0, src[7:1]};
               default: r = {cpu_p[0], src[7:1]};
            endcase
            set_flag(FLAG_C, row[1] ? src[0] : src[7]);
            set_nz(r);
            if (op[3:0] == 4'hA) cpu_a = r;
            else bus_write(it.ea, r);
            return;
         end
         case (row)
            ROW_STORE: bus_write(it.ea, cpu_x);
            ROW_LOAD: begin cpu_x = v; set_nz(v); end
            ROW_DEC: begin r = v - 8'd1; set_nz(r); bus_write(it.ea, r); end
            default: begin r = v + 8'd1; set_nz(r); bus_write(it.ea, r); end
         endcase
         return;
      end
      // Branches: row picks the flag (N, V, C, Z) and the wanted value.
      if (op[4:0] == 5'h10) begin
         case (row[2:1])
            2'd0: bmask = FLAG_N;
            2'd1: bmask = FLAG_V;
            2'd2: bmask = FLAG_C;
            default: bmask = FLAG_Z;
         endcase
         if (((cpu_p & bmask) != 8'h00) == row[0]) cpu_pc = cpu_pc + {{8{v[7]}}, v};
         return;
      end
      case (op)
         OP_BRK: begin
            ret = cpu_pc + 16'd1;
            stack_push(ret[15:8]);
            stack_push(ret[7:0]);
            stack_push(cpu_p | FLAG_B | FLAG_ONE);
            set_flag(FLAG_I, 1'b1);
            cpu_pc = it.bv;
            return;
         end
         OP_JSR: begin
            ret = cpu_pc - 16'd1;
            stack_push(ret[15:8]);
            stack_push(ret[7:0]);
            cpu_pc = it.ea;
            return;
         end
         OP_RTI: begin
            pull_status(it.p1);
            cpu_pc = {it.p3, it.p2};
            cpu_sp = cpu_sp + 8'd3;
            return;
         end
         OP_RTS: begin
            cpu_pc = {it.p2, it.p1} + 16'd1;
            cpu_sp = cpu_sp + 8'd2;
            return;
         end
         OP_JMP, OP_JMP_IND: begin cpu_pc = it.ea; return; end
         OP_PHP: begin stack_push(cpu_p | FLAG_B | FLAG_ONE); return; end
         OP_CLC: begin set_flag(FLAG_C, 1'b0); return; end
         OP_PLP: begin pull_status(it.p1); cpu_sp = cpu_sp + 8'd1; return; end
         OP_SEC: begin set_flag(FLAG_C, 1'b1); return; end
         OP_PHA: begin stack_push(cpu_a); return; end
         OP_CLI: begin set_flag(FLAG_I, 1'b0); return; end
         OP_PLA: begin cpu_a = it.p1; set_nz(it.p1); cpu_sp = cpu_sp + 8'd1; return; end
         OP_SEI: begin set_flag(FLAG_I, 1'b1); return; end
         OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); return; end
         OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); return; end
         OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); return; end
         OP_CLV: begin set_flag(FLAG_V, 1'b0); return; end
         OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); return; end
         OP_CLD: begin set_flag(FLAG_D, 1'b0); return; end
         OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); return; end
         OP_SED: begin set_flag(FLAG_D, 1'b1); return; end
         default: ;
      endcase
      case (row)
         ROW_BIT: begin
            set_flag(FLAG_Z, (cpu_a & v) == 8'h00);
            set_flag(FLAG_N, v[7]);
            set_flag(FLAG_V, v[6]);
         end
         ROW_STORE: bus_write(it.ea, cpu_y);
         ROW_LOAD: begin cpu_y = v; set_nz(v); end
         ROW_CPY: compare_reg(cpu_y, v);
         default: compare_reg(cpu_x, v);
      endcase
   endfunction

   // Advances the predicted state by one item and queues its results.
   function automatic void predict_results(exec_item_type it);
      bus_result_type res;
      logic bad;
      int n;
      bad = INSN_LEN[it.opcode] == 2'd0;
      bus_count = 0;
      if (bad) cpu_pc = cpu_pc + 16'd1;
      else begin
         cpu_pc = cpu_pc + {14'd0, INSN_LEN[it.opcode]};
         execute_instr(it);
      end
      n = (bus_count > 0) ? bus_count : 1;
      for (int k = 0; k < n; k++) begin
         res = '0;
         if (k < bus_count) begin
            res.wr_valid = 1'b1;
            res.wr_addr = bus_addr[k];
            res.wr_data = bus_data[k];
         end
         res.last = (k == n - 1);
         res.illegal = bad;
         res.a = cpu_a; res.x = cpu_x; res.y = cpu_y;
         res.sp = cpu_sp; res.p = cpu_p; res.pc = cpu_pc;
         bus_expected.push_back(res);
      end
   endfunction

   // Driver: inputs move on the falling edge.
   always @(negedge clock) begin
      exec_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took_item) begin
         if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = instr_queue.pop_front();
            req_opcode <= it.opcode;
            req_operand <= it.operand;
            req_effective_address <= it.ea;
            req_pulled_first <= it.p1;
            req_pulled_second <= it.p2;
            req_pulled_third <= it.p3;
            req_break_vector <= it.bv;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= reset || ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: check results first, then predict the item taken on this edge.
   always @(posedge clock) begin
      bus_result_type got, want;
      exec_item_type it;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_write_valid, rsp_write_address, rsp_write_data, rsp_last_of_run,
                   rsp_illegal_opcode, rsp_reg_a, rsp_reg_x, rsp_reg_y, rsp_stack_ptr,
                   rsp_flags, rsp_program_counter};
            if (bus_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = bus_expected.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            it = {req_opcode, req_operand, req_effective_address, req_pulled_first,
                  req_pulled_second, req_pulled_third, req_break_vector};
            predict_results(it);
         end
      end
      took_item <= !reset && req_valid && !req_stall;
   end

   task automatic add_item(logic [7:0] op, logic [7:0] v, logic [15:0] ea,
                           logic [7:0] p1, logic [7:0] p2, logic [7:0] p3, logic [15:0] bv);
      instr_queue.push_back({op, v, ea, p1, p2, p3, bv});
   endtask

   // Mostly documented opcodes with random content, some undocumented noise.
   task automatic add_random(int count);
      logic [7:0] op;
      for (int i = 0; i < count; i++) begin
         op = 8'($urandom_range(255));
         if ($urandom_range(99) < 88)
            while (INSN_LEN[op] == 2'd0) op = 8'($urandom_range(255));
         add_item(op, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 16'($urandom));
      end
   endtask

   // Waits until every item is taken and every result has arrived.
   task automatic drain();
      while (instr_queue.size() > 0 || req_valid || bus_expected.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_STACK_BASE) cfg_stack_base = value;
      else begin
         cfg_reset_pc = value;
         cpu_pc = value;
      end
   endtask

   initial begin
      cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
      cpu_sp = SP_RESET; cpu_p = STATUS_RESET;
      cfg_stack_base = STACK_BASE_RESET; cfg_reset_pc = RESET_PC_RESET;
      cpu_pc = RESET_PC_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: stack page at the top of memory so pushes wrap the address;
      // PC near the top so BRK return and length advance wrap too.
      send_idle_pct = 22; recv_idle_pct = 59;
      csr_write(CSR_STACK_BASE, 16'hFFFF);
      csr_write(CSR_RESET_PC, 16'hFFFE);
      add_item(OP_BRK, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
      add_item(OP_LDA_IMM, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_LDA_IMM, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      add_item(OP_ADC_IMM, 8'h80, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_SBC_IMM, 8'h7F, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_STA_ABSY, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_STA_ABS, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_PHP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_PLP, 8'h00, 16'h0000, 8'hFF, 8'h00, 8'h00, 16'h0000);  // B dropped
      add_item(OP_RTI, 8'h00, 16'h0000, 8'h10, 8'h34, 8'h12, 16'h0000);
      add_item(OP_JSR, 8'h00, 16'h8000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_RTS, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'h00, 16'h0000);  // PC wraps
      add_item(OP_LDX_IMM, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_TXS, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_PHA, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);  // SP wraps down
      add_item(OP_PLA, 8'h00, 16'h0000, 8'h80, 8'h00, 8'h00, 16'h0000);  // and back up
      add_item(OP_BAD_LOW, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_BAD_HIGH, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      add_item(OP_BMI, 8'h80, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);  // back 128
      add_item(OP_BNE, 8'h7F, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_INC_ABS, 8'hFF, 16'h1234, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_DEC_ZP, 8'h00, 16'h00FF, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_ROR_ABS, 8'h01, 16'hABCD, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_BIT_ZP, 8'hC0, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_item(OP_CPX_IMM, 8'h01, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      add_random(100);
      drain();

      // Phase 2: stack at address zero, PC mid-range, the other idle mix.
      send_idle_pct = 59; recv_idle_pct = 22;
      csr_write(CSR_STACK_BASE, 16'h0000);
      csr_write(CSR_RESET_PC, 16'h8000);
      add_random(125);
      drain();

      // Phase 3: random settings, no idling at all.
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_write(CSR_STACK_BASE, 16'($urandom));
      csr_write(CSR_RESET_PC, 16'($urandom));
      add_random(125);
      drain();

      if (mismatches == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
